>>> design/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
`default_nettype none
package sem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 24;
    localparam int PAIR_W     = 2 * PIX_W;
    localparam int SQ_W       = 21;
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int ROW_W      = 12;
    localparam int CNT_W      = 12;
    localparam int ADDR_W     = 3;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [7:0]       SAT_LIMIT    = 8'd255;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_ROOT,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> design/sem_line_buf.sv
// two line stores held as one memory of upper/middle pixel pairs
`default_nettype none
module sem_line_buf (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [sem_pkg::COL_W-1:0]    rd_addr,
    output logic      [sem_pkg::PAIR_W-1:0]   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [sem_pkg::COL_W-1:0]    wr_addr,
    input  wire logic [sem_pkg::PAIR_W-1:0]   wr_data
);

    logic [sem_pkg::PAIR_W-1:0] mem [sem_pkg::MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> design/sem_isqrt.sv
// iterative saturating integer square root, one result bit per cycle
`default_nettype none
module sem_isqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [sem_pkg::SQ_W-1:0]   value,
    output logic                            done,
    output logic      [7:0]                 root
);

    logic [sem_pkg::SQ_W-1:0] v_reg;
    logic [7:0]               r_reg;
    logic [2:0]               cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [7:0]               trial;
    logic [15:0]              trial_sq;

    assign trial    = r_reg | (8'd1 << cnt_reg);
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd7;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd7;
            end else if (busy_reg) begin
                if (cnt_reg == 3'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= value;
            r_reg <= 8'd0;
        end else if (busy_reg) begin
            if (sem_pkg::SQ_W'(trial_sq) <= v_reg) begin
                r_reg <= trial;
            end
        end
    end

    assign done = done_reg;
    assign root = (v_reg[sem_pkg::SQ_W-1:16] != '0) ? sem_pkg::SAT_LIMIT : r_reg;

endmodule
`default_nettype wire

>>> design/sobel_edge_magnitude_rgb.sv
// top level of the streaming rgb sobel edge magnitude filter
//
// input channel (s_*): one request per valid/ready handshake; s_req_type
// selects a pixel in raster order or a drain of one pending result.
// result channel (m_*): red/green/blue edge magnitudes and frame_end.
// results trail the input by one image line plus one pixel; after the last
// pixel of a frame, drain requests flush the border results still pending.
// config: apb port, img_width at 0x0, img_height at 0x4; a write restarts
// the frame (line stores are kept).
// throughput: one request at a time. a pixel that gives no result passes
// through the load state, a border result through load and output, an
// interior result through load, the gradient stage, an 8-step square root
// on each channel and output. a drain uses the output state when a border
// result is pending. m_valid rises when the output state moves the result
// into the output register.
// the result sits in an output register; the next request is accepted
// while it waits, and a further result waits until m_ready takes it.
// reset (aresetn low, synchronous) clears counters, window and valid,
// and sets width 640 and height 480; no clearing pass is run.
`default_nettype none
module sobel_edge_magnitude_rgb (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sem_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_req_type,
    input  wire logic [7:0]                   s_red_in,
    input  wire logic [7:0]                   s_green_in,
    input  wire logic [7:0]                   s_blue_in,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [7:0]                   m_red_edge,
    output logic      [7:0]                   m_green_edge,
    output logic      [7:0]                   m_blue_edge,
    output logic                              m_frame_end
);

    localparam int COL_W = sem_pkg::COL_W;
    localparam int WID_W = sem_pkg::WID_W;
    localparam int HGT_W = sem_pkg::HGT_W;
    localparam int ROW_W = sem_pkg::ROW_W;
    localparam int CNT_W = sem_pkg::CNT_W;
    localparam int PIX_W = sem_pkg::PIX_W;
    localparam int SQ_W  = sem_pkg::SQ_W;

    function automatic logic [SQ_W-1:0] chan_sumsq(input sem_pkg::win_t win, input int ch);
        logic [7:0] a [3][3];
        logic [9:0] xp, xn, yp, yn, ax, ay;
        logic [19:0] sx, sy;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a[i][j] = win[i][j][ch*8 +: 8];
            end
        end
        xp = 10'(a[0][2]) + {1'b0, a[1][2], 1'b0} + 10'(a[2][2]);
        xn = 10'(a[0][0]) + {1'b0, a[1][0], 1'b0} + 10'(a[2][0]);
        yp = 10'(a[2][0]) + {1'b0, a[2][1], 1'b0} + 10'(a[2][2]);
        yn = 10'(a[0][0]) + {1'b0, a[0][1], 1'b0} + 10'(a[0][2]);
        ax = (xp >= xn) ? xp - xn : xn - xp;
        ay = (yp >= yn) ? yp - yn : yn - yp;
        sx = 20'(ax) * 20'(ax);
        sy = 20'(ay) * 20'(ay);
        return SQ_W'(sx) + SQ_W'(sy);
    endfunction

    sem_pkg::state_t state_reg, state_next;

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;

    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_x_reg;
    logic [ROW_W-1:0] out_y_reg;
    logic [CNT_W-1:0] pend_reg;

    sem_pkg::win_t    win_reg;
    logic [PIX_W-1:0] pix_reg;

    logic [7:0] res_r_reg, res_g_reg, res_b_reg;
    logic       res_fe_reg;
    logic       m_valid_reg;
    logic [7:0] out_r_reg, out_g_reg, out_b_reg;
    logic       out_fe_reg;

    logic                         cfg_wr;
    logic                         accept;
    logic                         interior;
    logic                         last_pos;
    logic                         emit_now;
    logic                         out_free;
    logic [sem_pkg::PAIR_W-1:0]   rd_pair;
    logic [2:0]                   sq_done;
    logic [7:0]                   root [3];
    logic [SQ_W-1:0]              sumsq [3];
    logic                         sq_start;

    assign w_eff = (width_reg == '0) ? WID_W'(1) :
                   (width_reg > WID_W'(sem_pkg::MAX_WIDTH)) ? WID_W'(sem_pkg::MAX_WIDTH) :
                   width_reg;
    assign h_eff = (height_reg == '0) ? HGT_W'(1) :
                   (height_reg > HGT_W'(sem_pkg::MAX_HEIGHT)) ? HGT_W'(sem_pkg::MAX_HEIGHT) :
                   height_reg;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sem_pkg::REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign interior = (w_eff >= WID_W'(3)) && (h_eff >= HGT_W'(3)) &&
                      (out_y_reg != '0) && (HGT_W'(out_y_reg) + HGT_W'(2) <= h_eff) &&
                      (out_x_reg != '0) && (WID_W'(out_x_reg) + WID_W'(2) <= w_eff);
    assign last_pos = (WID_W'(out_x_reg) + WID_W'(1) == w_eff) &&
                      (HGT_W'(out_y_reg) + HGT_W'(1) == h_eff);
    assign emit_now = pend_reg > CNT_W'(w_eff);

    sem_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (rd_pair),
        .wr_en   (state_reg == sem_pkg::ST_LOAD),
        .wr_addr (in_col_reg),
        .wr_data ({rd_pair[PIX_W-1:0], pix_reg})
    );

    assign sq_start = (state_reg == sem_pkg::ST_GRAD);

    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign sumsq[c] = chan_sumsq(win_reg, c);
        sem_isqrt u_isqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (sq_start),
            .value   (sumsq[c]),
            .done    (sq_done[c]),
            .root    (root[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            sem_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_req_type == sem_pkg::REQ_PIXEL) begin
                        state_next = sem_pkg::ST_LOAD;
                    end else if (pend_reg != '0 && !interior) begin
                        state_next = sem_pkg::ST_OUT;
                    end
                end
            end
            sem_pkg::ST_LOAD: begin
                if (!emit_now) begin
                    state_next = sem_pkg::ST_IDLE;
                end else if (interior) begin
                    state_next = sem_pkg::ST_GRAD;
                end else begin
                    state_next = sem_pkg::ST_OUT;
                end
            end
            sem_pkg::ST_GRAD: begin
                state_next = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT: begin
                if (sq_done[0]) begin
                    state_next = sem_pkg::ST_OUT;
                end
            end
            sem_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end

    // counters, window and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_x_reg  <= '0;
            out_y_reg  <= '0;
            pend_reg   <= '0;
            win_reg    <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == sem_pkg::REG_WIDTH) begin
                width_reg <= pwdata[WID_W-1:0];
            end else begin
                height_reg <= pwdata[HGT_W-1:0];
            end
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_x_reg  <= '0;
            out_y_reg  <= '0;
            pend_reg   <= '0;
            win_reg    <= '0;
        end else begin
            if ((state_reg == sem_pkg::ST_LOAD && emit_now) ||
                (state_reg == sem_pkg::ST_IDLE && accept && s_req_type == sem_pkg::REQ_DRAIN &&
                 pend_reg != '0 && !interior)) begin
                if (WID_W'(out_x_reg) + WID_W'(1) >= w_eff) begin
                    out_x_reg <= '0;
                    if (HGT_W'(out_y_reg) + HGT_W'(1) >= h_eff) begin
                        out_y_reg <= '0;
                    end else begin
                        out_y_reg <= out_y_reg + ROW_W'(1);
                    end
                end else begin
                    out_x_reg <= out_x_reg + COL_W'(1);
                end
            end
            if (state_reg == sem_pkg::ST_IDLE && accept && s_req_type == sem_pkg::REQ_DRAIN &&
                pend_reg != '0 && !interior) begin
                pend_reg <= pend_reg - CNT_W'(1);
            end
            if (state_reg == sem_pkg::ST_LOAD) begin
                if (!emit_now) begin
                    pend_reg <= pend_reg + CNT_W'(1);
                end
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= rd_pair[sem_pkg::PAIR_W-1:PIX_W];
                win_reg[1][2] <= rd_pair[PIX_W-1:0];
                win_reg[2][2] <= pix_reg;
                if (WID_W'(in_col_reg) + WID_W'(1) >= w_eff) begin
                    in_col_reg <= '0;
                    if (HGT_W'(in_row_reg) + HGT_W'(1) >= h_eff) begin
                        in_row_reg <= '0;
                    end else begin
                        in_row_reg <= in_row_reg + ROW_W'(1);
                    end
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
        end
    end

    // request payload and pending result
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= {s_blue_in, s_green_in, s_red_in};
        end
        if ((state_reg == sem_pkg::ST_LOAD && emit_now) ||
            (state_reg == sem_pkg::ST_IDLE && accept)) begin
            res_fe_reg <= last_pos;
            res_r_reg  <= '0;
            res_g_reg  <= '0;
            res_b_reg  <= '0;
        end else if (state_reg == sem_pkg::ST_ROOT && sq_done[0]) begin
            res_r_reg <= root[0];
            res_g_reg <= root[1];
            res_b_reg <= root[2];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == sem_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sem_pkg::ST_OUT && out_free) begin
            out_r_reg  <= res_r_reg;
            out_g_reg  <= res_g_reg;
            out_b_reg  <= res_b_reg;
            out_fe_reg <= res_fe_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_edge   = out_r_reg;
    assign m_green_edge = out_g_reg;
    assign m_blue_edge  = out_b_reg;
    assign m_frame_end  = out_fe_reg;

endmodule
`default_nettype wire

>>> design/sem_checker.sv
// port-level checks for the sobel edge magnitude block, with its bind
`default_nettype none
module sem_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       pready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_red_edge
);

    a_pready_high: assert property (@(posedge aclk) pready)
        else $error("pready low");

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_edge))
        else $error("stalled result changed");

    a_no_accept_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !(m_valid && m_ready))
        else $error("result taken right after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .pready     (pready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_red_edge (m_red_edge)
);
`default_nettype wire
